/* rtl/pid_speed_controller_core_macros.svh */
// ---------------------------------------------------------------------------
// PID speed controller assertion macros
// Concurrent assertion helpers, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef PID_SPEED_CONTROLLER_CORE_MACROS_SVH
`define PID_SPEED_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication.
`define PSC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pid_speed_controller_core: same-cycle check failed");

// Next-cycle implication.
`define PSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pid_speed_controller_core: next-cycle check failed");

`endif

/* rtl/psc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PID speed controller package
// Shared types, register map codes and reset values.
// ---------------------------------------------------------------------------
package psc_pkg;

    localparam logic [2:0] REG_SETPOINT       = 3'd0;
    localparam logic [2:0] REG_PROP_GAIN      = 3'd1;
    localparam logic [2:0] REG_INTEG_GAIN     = 3'd2;
    localparam logic [2:0] REG_DERIV_GAIN     = 3'd3;
    localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd4;
    localparam logic [2:0] REG_DRIVE_LIMIT    = 3'd5;

    localparam logic signed [15:0] SETPOINT_RST       = 16'sd0;
    localparam logic [15:0]        PROP_GAIN_RST      = 16'd4096;
    localparam logic [15:0]        INTEG_GAIN_RST     = 16'd410;
    localparam logic [15:0]        DERIV_GAIN_RST     = 16'd0;
    localparam logic [14:0]        INTEGRAL_LIMIT_RST = 15'd5120;
    localparam logic [14:0]        DRIVE_LIMIT_RST    = 15'd25600;

    localparam logic signed [16:0] FILT_NEW_WEIGHT = 17'sd179;
    localparam logic signed [16:0] FILT_OLD_WEIGHT = 17'sd77;

    typedef struct packed {
        logic signed [15:0] setpoint;
        logic [15:0]        prop_gain;
        logic [15:0]        integ_gain;
        logic [15:0]        deriv_gain;
        logic [14:0]        integral_limit;
        logic [14:0]        drive_limit;
    } psc_cfg_t;

    typedef enum logic [2:0] {
        MSEL_PROP     = 3'd0,
        MSEL_INTEG    = 3'd1,
        MSEL_DERIV    = 3'd2,
        MSEL_FILT_NEW = 3'd3,
        MSEL_FILT_OLD = 3'd4
    } psc_msel_t;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } psc_acc_op_t;

    typedef struct packed {
        logic        capture;
        psc_msel_t   msel;
        psc_acc_op_t acc_op;
        logic        raw_latch;
        logic        finish;
    } psc_cmd_t;

endpackage

/* rtl/pid_speed_controller_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PID speed controller core
// Channel   Dir   Transfer on                 Payload
// s_axis    in    s_axis_tvalid & tready      tdata[15:0] measured_speed
// m_axis    out   m_axis_tvalid & tready      tdata[15:0] drive, tuser[0] at_limit
// apb       in    psel & penable & pwrite     six 32-bit registers at 4*i
//
// Each sample runs from the capture in idle through eight steps on the
// shared 17x25 multiplier and accumulator to the done state, where the
// result is written out; a new sample is taken only back in idle.
// The result is registered as the done state writes it out.
// The next sample is accepted while a result still waits; its own result is
// held in the done state until the waiting one has been taken.
// Reset restores the register defaults and the first-sample bypass of the filter.
// ---------------------------------------------------------------------------
module pid_speed_controller_core
    import psc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] measured_speed
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] drive
    output logic [0:0]  m_axis_tuser,   // [0] at_limit
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    psc_cfg_t           cfg;
    psc_cmd_t           cmd;
    logic signed [15:0] drive;
    logic               at_limit;

    psc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    psc_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .measured_speed ($signed(s_axis_tdata)),
        .drive          (drive),
        .at_limit       (at_limit)
    );

    psc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    assign m_axis_tdata    = drive;
    assign m_axis_tuser[0] = at_limit;

endmodule

/* rtl/psc_regs.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PID speed controller register file
// APB-style configuration registers for setpoint, gains and limits.
// ---------------------------------------------------------------------------
module psc_regs
    import psc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output psc_cfg_t    cfg
);

    psc_cfg_t   cfg_reg;
    psc_cfg_t   cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_SETPOINT:       cfg_next.setpoint       = $signed(pwdata[15:0]);
                REG_PROP_GAIN:      cfg_next.prop_gain      = pwdata[15:0];
                REG_INTEG_GAIN:     cfg_next.integ_gain     = pwdata[15:0];
                REG_DERIV_GAIN:     cfg_next.deriv_gain     = pwdata[15:0];
                REG_INTEGRAL_LIMIT: cfg_next.integral_limit = pwdata[14:0];
                REG_DRIVE_LIMIT:    cfg_next.drive_limit    = pwdata[14:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SETPOINT:       prdata = {{16{cfg_reg.setpoint[15]}}, cfg_reg.setpoint};
            REG_PROP_GAIN:      prdata = {16'd0, cfg_reg.prop_gain};
            REG_INTEG_GAIN:     prdata = {16'd0, cfg_reg.integ_gain};
            REG_DERIV_GAIN:     prdata = {16'd0, cfg_reg.deriv_gain};
            REG_INTEGRAL_LIMIT: prdata = {17'd0, cfg_reg.integral_limit};
            REG_DRIVE_LIMIT:    prdata = {17'd0, cfg_reg.drive_limit};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint       <= SETPOINT_RST;
            cfg_reg.prop_gain      <= PROP_GAIN_RST;
            cfg_reg.integ_gain     <= INTEG_GAIN_RST;
            cfg_reg.deriv_gain     <= DERIV_GAIN_RST;
            cfg_reg.integral_limit <= INTEGRAL_LIMIT_RST;
            cfg_reg.drive_limit    <= DRIVE_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/psc_dp.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PID speed controller datapath
// Error and integral update, one shared multiplier, accumulator, filter and
// output saturation, driven step by step by the controller.
// ---------------------------------------------------------------------------
module psc_dp
    import psc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  psc_cfg_t           cfg,
    input  psc_cmd_t           cmd,
    input  logic signed [15:0] measured_speed,
    output logic signed [15:0] drive,
    output logic               at_limit
);

    logic signed [15:0] integral_reg;
    logic signed [15:0] integral_next;
    logic signed [16:0] prev_err_reg;
    logic signed [16:0] prev_err_next;
    logic signed [17:0] diff_reg;
    logic signed [17:0] diff_next;
    logic signed [15:0] filt_reg;
    logic signed [15:0] filt_next;
    logic               first_reg;
    logic               first_next;
    logic signed [41:0] prod_reg;
    logic signed [41:0] prod_next;
    logic signed [37:0] acc_reg;
    logic signed [37:0] acc_next;
    logic signed [24:0] raw_reg;
    logic signed [24:0] raw_next;
    logic signed [15:0] drive_reg;
    logic signed [15:0] drive_next;
    logic               at_limit_reg;
    logic               at_limit_next;

    logic signed [16:0] err_c;
    logic signed [17:0] isum_c;
    logic signed [17:0] ilim_c;
    logic signed [16:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [24:0] val_c;
    logic signed [24:0] dlim_c;
    logic signed [24:0] sat_c;

    // The error of the current sample is held in prev_err_reg once captured.
    assign err_c  = $signed({cfg.setpoint[15], cfg.setpoint})
                  - $signed({measured_speed[15], measured_speed});
    assign isum_c = $signed({{2{integral_reg[15]}}, integral_reg}) + $signed({err_c[16], err_c});
    assign ilim_c = $signed({3'b000, cfg.integral_limit});

    always_comb
    begin
        priority if (isum_c > ilim_c)
            integral_next = ilim_c[15:0];
        else if (isum_c < -ilim_c)
            integral_next = 16'(-ilim_c);
        else
            integral_next = isum_c[15:0];
    end

    assign prev_err_next = cmd.capture ? err_c : prev_err_reg;
    assign diff_next     = cmd.capture
                         ? $signed({err_c[16], err_c}) - $signed({prev_err_reg[16], prev_err_reg})
                         : diff_reg;

    always_comb
    begin
        unique case (cmd.msel)
            MSEL_PROP:
            begin
                mul_a = $signed({1'b0, cfg.prop_gain});
                mul_b = 25'(prev_err_reg);
            end
            MSEL_INTEG:
            begin
                mul_a = $signed({1'b0, cfg.integ_gain});
                mul_b = 25'(integral_reg);
            end
            MSEL_DERIV:
            begin
                mul_a = $signed({1'b0, cfg.deriv_gain});
                mul_b = 25'(diff_reg);
            end
            MSEL_FILT_NEW:
            begin
                mul_a = FILT_NEW_WEIGHT;
                mul_b = raw_reg;
            end
            MSEL_FILT_OLD:
            begin
                mul_a = FILT_OLD_WEIGHT;
                mul_b = 25'(filt_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_comb
    begin
        unique case (cmd.acc_op)
            ACC_LOAD: acc_next = prod_reg[37:0];
            ACC_ADD:  acc_next = acc_reg + prod_reg[37:0];
            default:  acc_next = acc_reg;
        endcase
    end

    // Arithmetic shifts round toward minus infinity.
    assign raw_next = cmd.raw_latch ? acc_reg[36:12] : raw_reg;
    assign val_c    = first_reg ? raw_reg : acc_reg[32:8];
    assign dlim_c   = $signed({10'd0, cfg.drive_limit});

    always_comb
    begin
        priority if (val_c > dlim_c)
            sat_c = dlim_c;
        else if (val_c < -dlim_c)
            sat_c = -dlim_c;
        else
            sat_c = val_c;
    end

    assign filt_next     = cmd.finish ? sat_c[15:0] : filt_reg;
    assign first_next    = cmd.finish ? 1'b0 : first_reg;
    assign drive_next    = cmd.finish ? sat_c[15:0] : drive_reg;
    assign at_limit_next = cmd.finish ? (sat_c != val_c) : at_limit_reg;

    assign drive    = drive_reg;
    assign at_limit = at_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            prev_err_reg <= '0;
            filt_reg     <= '0;
            first_reg    <= 1'b1;
        end
        else
        begin
            if (cmd.capture)
            begin
                integral_reg <= integral_next;
            end
            prev_err_reg <= prev_err_next;
            filt_reg     <= filt_next;
            first_reg    <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg     <= diff_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        raw_reg      <= raw_next;
        drive_reg    <= drive_next;
        at_limit_reg <= at_limit_next;
    end

endmodule

/* rtl/psc_ctrl.sv */
`timescale 1ns / 1ps
`include "pid_speed_controller_core_macros.svh"
// ---------------------------------------------------------------------------
// PID speed controller sequencer
// One-hot state machine that steps the datapath through one sample and owns
// the input ready and the output valid.
// ---------------------------------------------------------------------------
module psc_ctrl
    import psc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output psc_cmd_t cmd
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_MP   = 10'b00_0000_0010,
        S_MI   = 10'b00_0000_0100,
        S_MD   = 10'b00_0000_1000,
        S_ACC  = 10'b00_0001_0000,
        S_RAW  = 10'b00_0010_0000,
        S_F1   = 10'b00_0100_0000,
        S_F2   = 10'b00_1000_0000,
        S_FACC = 10'b01_0000_0000,
        S_DONE = 10'b10_0000_0000
    } psc_state_t;

    psc_state_t state_reg;
    psc_state_t state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = m_valid_reg;
    assign out_free  = !m_valid_reg || out_ready;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture   = 1'b0;
        cmd.msel      = MSEL_PROP;
        cmd.acc_op    = ACC_HOLD;
        cmd.raw_latch = 1'b0;
        cmd.finish    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_MP;
                end
            end
            S_MP:
            begin
                cmd.msel   = MSEL_PROP;
                state_next = S_MI;
            end
            S_MI:
            begin
                cmd.msel   = MSEL_INTEG;
                cmd.acc_op = ACC_LOAD;
                state_next = S_MD;
            end
            S_MD:
            begin
                cmd.msel   = MSEL_DERIV;
                cmd.acc_op = ACC_ADD;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_op = ACC_ADD;
                state_next = S_RAW;
            end
            S_RAW:
            begin
                cmd.raw_latch = 1'b1;
                state_next    = S_F1;
            end
            S_F1:
            begin
                cmd.msel   = MSEL_FILT_NEW;
                state_next = S_F2;
            end
            S_F2:
            begin
                cmd.msel   = MSEL_FILT_OLD;
                cmd.acc_op = ACC_LOAD;
                state_next = S_FACC;
            end
            S_FACC:
            begin
                cmd.acc_op = ACC_ADD;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (out_ready)
        begin
            m_valid_next = 1'b0;
        end
        if (cmd.finish)
        begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // A finished result never overwrites one that is still waiting.
    `PSC_ASSERT_IMPL(a_no_overwrite, cmd.finish, !m_valid_reg || out_ready)
    `PSC_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_reg == S_MP)
    `PSC_ASSERT_NEXT(a_finish_shows, cmd.finish, m_valid_reg && state_reg == S_IDLE)

endmodule

/* tb/pid_drive_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PID speed controller drive checker
// Watches the sample, drive and register channels of the controller. It
// keeps its own copy of the register set and of the loop state, works out
// the drive and limit flag for every accepted sample, and compares each
// drive transfer with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module pid_drive_checker
    import psc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] measured_speed
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [15:0] drive
    input  logic [0:0]  m_axis_tuser,   // [0] at_limit
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          drives_pending,
    output int          mismatch_count
);

    localparam longint NEW_SHARE = 179;
    localparam longint OLD_SHARE = 77;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               at_limit;
    } drive_result_t;

    psc_cfg_t           loop_cfg;
    logic signed [15:0] integ_acc;
    logic signed [16:0] last_error;
    logic signed [15:0] last_drive;
    logic               bypass_filter;
    drive_result_t      drive_q[$];

    function automatic longint clamp_to(input longint v, input longint bound);
        if (v > bound)
            return bound;
        if (v < -bound)
            return -bound;
        return v;
    endfunction

    task automatic predict_drive(input logic signed [15:0] speed);
        longint        err;
        longint        integ;
        longint        gain_sum;
        longint        raw;
        longint        blended;
        longint        limited;
        drive_result_t res;
        err      = longint'($signed(loop_cfg.setpoint)) - longint'(speed);
        integ    = clamp_to(longint'(integ_acc) + err, longint'(loop_cfg.integral_limit));
        gain_sum = longint'(loop_cfg.prop_gain) * err
                 + longint'(loop_cfg.integ_gain) * integ
                 + longint'(loop_cfg.deriv_gain) * (err - longint'(last_error));
        raw      = gain_sum >>> 12;
        if (bypass_filter)
            blended = raw;
        else
            blended = (NEW_SHARE * raw + OLD_SHARE * longint'(last_drive)) >>> 8;
        limited  = clamp_to(blended, longint'(loop_cfg.drive_limit));
        integ_acc     = integ[15:0];
        last_error    = err[16:0];
        last_drive    = limited[15:0];
        bypass_filter = 1'b0;
        res.drive    = limited[15:0];
        res.at_limit = (limited != blended);
        drive_q.push_back(res);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [31:0] value);
        case (index)
            REG_SETPOINT:       loop_cfg.setpoint       = value[15:0];
            REG_PROP_GAIN:      loop_cfg.prop_gain      = value[15:0];
            REG_INTEG_GAIN:     loop_cfg.integ_gain     = value[15:0];
            REG_DERIV_GAIN:     loop_cfg.deriv_gain     = value[15:0];
            REG_INTEGRAL_LIMIT: loop_cfg.integral_limit = value[14:0];
            REG_DRIVE_LIMIT:    loop_cfg.drive_limit    = value[14:0];
            default:            ;
        endcase
    endtask

    task automatic check_drive();
        drive_result_t exp_res;
        if (drive_q.size() == 0)
        begin
            $error("drive transfer with no sample outstanding: drive %0d at_limit %0b",
                   $signed(m_axis_tdata), m_axis_tuser[0]);
            mismatch_count++;
        end
        else
        begin
            exp_res = drive_q.pop_front();
            if (m_axis_tdata !== exp_res.drive)
            begin
                $error("drive: expected %0d, actual %0d", exp_res.drive,
                       $signed(m_axis_tdata));
                mismatch_count++;
            end
            if (m_axis_tuser[0] !== exp_res.at_limit)
            begin
                $error("at_limit: expected %0b, actual %0b", exp_res.at_limit,
                       m_axis_tuser[0]);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_cfg.setpoint       = SETPOINT_RST;
            loop_cfg.prop_gain      = PROP_GAIN_RST;
            loop_cfg.integ_gain     = INTEG_GAIN_RST;
            loop_cfg.deriv_gain     = DERIV_GAIN_RST;
            loop_cfg.integral_limit = INTEGRAL_LIMIT_RST;
            loop_cfg.drive_limit    = DRIVE_LIMIT_RST;
            integ_acc     = '0;
            last_error    = '0;
            last_drive    = '0;
            bypass_filter = 1'b1;
            drive_q.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_drive();
            if (s_axis_tvalid && s_axis_tready)
                predict_drive($signed(s_axis_tdata));
            if (psel && penable && pwrite && pready)
                write_register(paddr[4:2], pwdata);
        end
        drives_pending = drive_q.size();
    end

endmodule

/* tb/tb_pid_speed_controller_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PID speed controller testbench
// Drives speed samples into the controller under a series of register
// settings, starting with directed extremes (full-scale samples and gains,
// zero drive bound, zero integral clamp, unused register addresses) and
// going on with random phases of plant-like and random samples. Both
// stream sides idle at random, and the drive side once holds off long
// enough to back up the sample input. A separate checker judges every drive.
// ---------------------------------------------------------------------------
module tb_pid_speed_controller_core
    import psc_pkg::*;
();

    localparam int          PHASE_COUNT      = 12;
    localparam int          SAMPLES_PER_PHASE = 127;
    localparam int          HOLD_AT_DRIVE    = 600;
    localparam int          HOLD_CYCLES      = 400;
    localparam int          DRAIN_CYCLES     = 30;
    localparam int unsigned RUN_LIMIT_NS     = 5_000_000;
    localparam logic [2:0]  REG_UNUSED_LO    = 3'd6;
    localparam logic [2:0]  REG_UNUSED_HI    = 3'd7;

    localparam logic [15:0] EDGE_SPEEDS [8] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001,
                                                16'hFFFF, 16'h5555, 16'hAAAA, 16'h0000};

    typedef enum logic [1:0] {
        SPEED_RANDOM,
        SPEED_NEAR,
        SPEED_STEP
    } speed_mode_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [15:0] s_axis_tdata  = '0;
    logic        m_axis_tready = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [4:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic [31:0] prdata;
    logic        pready;

    int                 drives_pending;
    int                 mismatch_count;
    int                 drives_taken;
    bit                 sender_steady;
    bit                 receiver_steady;
    speed_mode_t        speed_mode;
    logic signed [15:0] cur_setpoint;
    int                 noise_span;
    int                 plant_speed;

    pid_speed_controller_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    pid_drive_checker drive_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .drives_pending (drives_pending),
        .mismatch_count (mismatch_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

    task automatic write_register(input logic [2:0] index, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_sample(input logic [15:0] speed);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= speed;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (drives_pending == 0);
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom);
            default: return 16'($urandom_range(0, 8192));
        endcase
    endfunction

    function automatic logic [14:0] pick_bound();
        case ($urandom_range(0, 7))
            0:       return 15'h0000;
            1:       return 15'h7FFF;
            2, 3:    return 15'($urandom);
            default: return 15'($urandom_range(64, 12800));
        endcase
    endfunction

    function automatic logic [15:0] pick_setpoint();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 16384)) - 8192);
        endcase
    endfunction

    function automatic logic [15:0] next_speed();
        case (speed_mode)
            SPEED_NEAR:
                return 16'(int'(cur_setpoint) + int'($urandom_range(0, 2 * noise_span))
                           - noise_span);
            SPEED_STEP:
            begin
                plant_speed = plant_speed + (int'(cur_setpoint) - plant_speed) / 8
                            + int'($urandom_range(0, 64)) - 32;
                return 16'(plant_speed);
            end
            default:
                return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        int hold;
        wait (rst_n);
        forever
        begin
            if (drives_taken == HOLD_AT_DRIVE)
                hold = HOLD_CYCLES;
            else if (receiver_steady)
                hold = 0;
            else
                hold = $urandom_range(0, 9);
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            drives_taken++;
            if (drives_taken % 97 == 0)
                receiver_steady = ($urandom_range(0, 2) == 0);
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (EDGE_SPEEDS[i])
            send_sample(EDGE_SPEEDS[i]);
        settle();

        write_register(REG_DRIVE_LIMIT, 32'hFFFF_8000);
        write_register(REG_INTEGRAL_LIMIT, 32'h0001_0000);
        write_register(REG_PROP_GAIN, 32'h0000_FFFF);
        write_register(REG_INTEG_GAIN, 32'hFFFF_FFFF);
        write_register(REG_DERIV_GAIN, 32'hA5A5_FFFF);
        write_register(REG_SETPOINT, 32'h1234_7FFF);
        write_register(REG_UNUSED_LO, 32'hFFFF_FFFF);
        write_register(REG_UNUSED_HI, 32'h0000_0000);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h0000);
        send_sample(16'h0064);
        settle();

        write_register(REG_DRIVE_LIMIT, 32'h0000_7FFF);
        write_register(REG_INTEGRAL_LIMIT, 32'hFFFF_7FFF);
        write_register(REG_SETPOINT, 32'hFFFF_8000);
        write_register(REG_PROP_GAIN, 32'hFFFF_0000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        settle();

        write_register(REG_PROP_GAIN, 32'd4096);
        write_register(REG_INTEG_GAIN, 32'd410);
        write_register(REG_DERIV_GAIN, 32'd2048);
        write_register(REG_INTEGRAL_LIMIT, 32'd256);
        write_register(REG_DRIVE_LIMIT, 32'd12800);
        write_register(REG_SETPOINT, 32'd1000);
        repeat (6) send_sample(16'h0000);
        settle();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            cur_setpoint = pick_setpoint();
            write_register(REG_SETPOINT, {16'($urandom), cur_setpoint});
            write_register(REG_PROP_GAIN, {16'($urandom), pick_gain()});
            write_register(REG_INTEG_GAIN, {16'($urandom), pick_gain()});
            write_register(REG_DERIV_GAIN, {16'($urandom), pick_gain()});
            write_register(REG_INTEGRAL_LIMIT, {17'($urandom), pick_bound()});
            write_register(REG_DRIVE_LIMIT, {17'($urandom), pick_bound()});
            case ($urandom_range(0, 3))
                0:       speed_mode = SPEED_RANDOM;
                1:       speed_mode = SPEED_STEP;
                default: speed_mode = SPEED_NEAR;
            endcase
            case ($urandom_range(0, 2))
                0:       noise_span = 16;
                1:       noise_span = 256;
                default: noise_span = 4096;
            endcase
            plant_speed   = int'($signed(16'($urandom)));
            sender_steady = ($urandom_range(0, 3) == 0);
            repeat (SAMPLES_PER_PHASE)
                send_sample(next_speed());
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
